>>> rtl/cccv_pkg.sv
// Shared types and constants for the CC-CV cycling controller.
// Used by cccv_cfg_regs, cccv_step_core and cccv_cycling_controller.
`timescale 1ns / 1ps
`default_nettype none

package cccv_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int HCN_W       = 16;
  localparam int CFG_DATA_W  = 48;
  localparam int CFG_IDX_W   = 3;
  localparam int MODE_W      = 9;

  // phase codes
  localparam logic [1:0] PH_INIT  = 2'd0;
  localparam logic [1:0] PH_CC    = 2'd1;
  localparam logic [1:0] PH_CV    = 2'd2;
  localparam logic [1:0] PH_RELAX = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CYCLE_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHG_CUT_V   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIS_CUT_V   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CHG_CUT_C   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIS_CUT_C   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CHG_RELAX_T = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DIS_RELAX_T = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ADAPT_WIN   = 3'd7;

  // cycle_mode bits
  localparam int MODE_CHARGE_FIRST = 0;
  localparam int MODE_SKIP_INIT    = 1;
  localparam int MODE_ADAPT_INIT   = 2;
  localparam int MODE_ADAPT_CHG    = 3;
  localparam int MODE_ADAPT_DIS    = 6;

  typedef struct packed {
    logic               start_cycling;
    logic [31:0]        step_number;
    logic [47:0]        sim_time;
    logic signed [31:0] cell_voltage;
    logic signed [31:0] cell_crate;
  } cccv_in_t;

  typedef struct packed {
    logic [1:0]       phase;
    logic             charging;
    logic [HCN_W-1:0] half_cycle_number;
    logic             phase_advanced;
    logic             half_cycle_done;
    logic             adapt_window_over;
    logic             adaptive_stepping;
  } cccv_out_t;

  typedef struct packed {
    logic [MODE_W-1:0]  cycle_mode;
    logic signed [31:0] charge_cutoff_voltage;
    logic signed [31:0] discharge_cutoff_voltage;
    logic signed [31:0] charge_cutoff_crate;
    logic signed [31:0] discharge_cutoff_crate;
    logic [47:0]        charge_relax_time;
    logic [47:0]        discharge_relax_time;
    logic [31:0]        adapt_window_steps;
  } cccv_cfg_t;

endpackage

`default_nettype wire

>>> rtl/cccv_cfg_regs.sv
// Configuration register file for the CC-CV cycling controller.
// Depends on cccv_pkg for the register indexes and the config struct.
`timescale 1ns / 1ps
`default_nettype none

module cccv_cfg_regs (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_write,
  input  wire logic [cccv_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [cccv_pkg::CFG_DATA_W-1:0]  cfg_data,
  output cccv_pkg::cccv_cfg_t                   cfg
);
  import cccv_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cycle_mode               <= MODE_W'(1);
      cfg.charge_cutoff_voltage    <= '0;
      cfg.discharge_cutoff_voltage <= '0;
      cfg.charge_cutoff_crate      <= '0;
      cfg.discharge_cutoff_crate   <= '0;
      cfg.charge_relax_time        <= '0;
      cfg.discharge_relax_time     <= '0;
      cfg.adapt_window_steps       <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_CYCLE_MODE:  cfg.cycle_mode               <= cfg_data[MODE_W-1:0];
        REG_CHG_CUT_V:   cfg.charge_cutoff_voltage    <= $signed(cfg_data[31:0]);
        REG_DIS_CUT_V:   cfg.discharge_cutoff_voltage <= $signed(cfg_data[31:0]);
        REG_CHG_CUT_C:   cfg.charge_cutoff_crate      <= $signed(cfg_data[31:0]);
        REG_DIS_CUT_C:   cfg.discharge_cutoff_crate   <= $signed(cfg_data[31:0]);
        REG_CHG_RELAX_T: cfg.charge_relax_time        <= cfg_data[47:0];
        REG_DIS_RELAX_T: cfg.discharge_relax_time     <= cfg_data[47:0];
        REG_ADAPT_WIN:   cfg.adapt_window_steps       <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/cccv_step_core.sv
// Cycling state and per-step evaluation: phase end tests, phase advance,
// adaptive window and flag. Depends on cccv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cccv_step_core (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          step_en,
  input  wire cccv_pkg::cccv_in_t  item,
  input  wire cccv_pkg::cccv_cfg_t cfg,
  output cccv_pkg::cccv_out_t result
);
  import cccv_pkg::*;

  logic                   charging_flag, charging_flag_next;
  logic [COUNT_WIDTH-1:0] half_cycle_count, half_cycle_count_next;
  logic [1:0]             charge_phase, charge_phase_next;
  logic [1:0]             discharge_phase, discharge_phase_next;
  logic [47:0]            charge_relax_end, charge_relax_end_next;
  logic [47:0]            discharge_relax_end, discharge_relax_end_next;
  logic                   change_pending, change_pending_next;
  logic [31:0]            last_change_step, last_change_step_next;

  logic        skip;
  logic [1:0]  cur;
  logic        hit;
  logic        advanced;
  logic        done;
  logic        pend_mid;
  logic        over;
  logic        adapt;
  logic [1:0]  phase_out;
  logic [48:0] end_sum;
  logic [47:0] end_sat;
  logic [32:0] win_end;

  always_comb begin
    charging_flag_next       = charging_flag;
    half_cycle_count_next    = half_cycle_count;
    charge_phase_next        = charge_phase;
    discharge_phase_next     = discharge_phase;
    charge_relax_end_next    = charge_relax_end;
    discharge_relax_end_next = discharge_relax_end;
    pend_mid                 = change_pending;
    last_change_step_next    = last_change_step;
    advanced                 = 1'b0;
    done                     = 1'b0;
    hit                      = 1'b0;
    skip                     = cfg.cycle_mode[MODE_SKIP_INIT];
    cur                      = charging_flag ? charge_phase : discharge_phase;

    end_sum = {1'b0, item.sim_time} +
              {1'b0, (charging_flag ? cfg.charge_relax_time : cfg.discharge_relax_time)};
    end_sat = end_sum[48] ? '1 : end_sum[47:0];

    if (half_cycle_count == '0) begin
      if (skip || item.start_cycling) begin
        if (!skip) begin
          pend_mid              = 1'b1;
          last_change_step_next = item.step_number;
          advanced              = 1'b1;
        end
        charging_flag_next    = cfg.cycle_mode[MODE_CHARGE_FIRST];
        half_cycle_count_next = COUNT_WIDTH'(1);
        charge_phase_next     = PH_CC;
        discharge_phase_next  = PH_CC;
      end
    end else begin
      case (cur)
        PH_CC:
          hit = charging_flag ? (item.cell_voltage >= cfg.charge_cutoff_voltage)
                              : (item.cell_voltage <= cfg.discharge_cutoff_voltage);
        PH_CV:
          hit = item.cell_crate <= (charging_flag ? cfg.charge_cutoff_crate
                                                  : cfg.discharge_cutoff_crate);
        default:
          hit = item.sim_time >= (charging_flag ? charge_relax_end : discharge_relax_end);
      endcase
      if (hit) begin
        advanced              = 1'b1;
        pend_mid              = 1'b1;
        last_change_step_next = item.step_number;
        case (cur)
          PH_CC: begin
            if (charging_flag) charge_phase_next = PH_CV;
            else               discharge_phase_next = PH_CV;
          end
          PH_CV: begin
            if (charging_flag) begin
              charge_relax_end_next = end_sat;
              charge_phase_next     = PH_RELAX;
            end else begin
              discharge_relax_end_next = end_sat;
              discharge_phase_next     = PH_RELAX;
            end
          end
          default: begin
            // end of half-cycle: rearm the other direction and flip
            done = 1'b1;
            if (charging_flag) discharge_phase_next = PH_CC;
            else               charge_phase_next = PH_CC;
            charging_flag_next = !charging_flag;
            if (half_cycle_count != '1)
              half_cycle_count_next = half_cycle_count + COUNT_WIDTH'(1);
          end
        endcase
      end
    end

    win_end             = {1'b0, last_change_step_next} + {1'b0, cfg.adapt_window_steps};
    over                = pend_mid && ({1'b0, item.step_number} >= win_end);
    change_pending_next = pend_mid && !over;

    if (half_cycle_count_next == '0) begin
      phase_out = PH_INIT;
      adapt     = cfg.cycle_mode[MODE_ADAPT_INIT];
    end else begin
      phase_out = charging_flag_next ? charge_phase_next : discharge_phase_next;
      case (phase_out)
        PH_CC:
          adapt = charging_flag_next ? cfg.cycle_mode[MODE_ADAPT_CHG]
                                     : cfg.cycle_mode[MODE_ADAPT_DIS];
        PH_CV:
          adapt = charging_flag_next ? cfg.cycle_mode[MODE_ADAPT_CHG + 1]
                                     : cfg.cycle_mode[MODE_ADAPT_DIS + 1];
        PH_RELAX:
          adapt = charging_flag_next ? cfg.cycle_mode[MODE_ADAPT_CHG + 2]
                                     : cfg.cycle_mode[MODE_ADAPT_DIS + 2];
        // an init code picks the bit past the charging group, else zero
        default:
          adapt = charging_flag_next ? cfg.cycle_mode[MODE_ADAPT_DIS] : 1'b0;
      endcase
    end

    result.phase             = phase_out;
    result.charging          = (half_cycle_count_next != '0) && charging_flag_next;
    result.half_cycle_number = HCN_W'(half_cycle_count_next);
    result.phase_advanced    = advanced;
    result.half_cycle_done   = done;
    result.adapt_window_over = over;
    result.adaptive_stepping = adapt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      charging_flag       <= 1'b0;
      half_cycle_count    <= '0;
      charge_phase        <= PH_CC;
      discharge_phase     <= PH_CC;
      charge_relax_end    <= '0;
      discharge_relax_end <= '0;
      change_pending      <= 1'b0;
      last_change_step    <= '0;
    end else if (step_en) begin
      charging_flag       <= charging_flag_next;
      half_cycle_count    <= half_cycle_count_next;
      charge_phase        <= charge_phase_next;
      discharge_phase     <= discharge_phase_next;
      charge_relax_end    <= charge_relax_end_next;
      discharge_relax_end <= discharge_relax_end_next;
      change_pending      <= change_pending_next;
      last_change_step    <= last_change_step_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/cccv_cycling_controller.sv
// CC-CV cycling controller top level: input register, step core, result register.
// An input transfer loads the item register; the core then advances it into the result
// register unless that is full and not draining. Throughput: one item per cycle while
// out_ready holds; the core updates the cycling state in the same cycle it evaluates.
// Reset (rst, synchronous): empty pipeline, registers to defaults, initial relaxation.
// Depends on cccv_pkg, cccv_cfg_regs and cccv_step_core.
`timescale 1ns / 1ps
`default_nettype none

module cccv_cycling_controller (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire cccv_pkg::cccv_in_t               in_data,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output cccv_pkg::cccv_out_t                   out_data,
  input  wire logic                             cfg_write,
  input  wire logic [cccv_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [cccv_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import cccv_pkg::*;

  cccv_cfg_t cfg;
  cccv_in_t  item;
  logic      item_valid;
  logic      step_en;
  cccv_out_t result;

  cccv_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  cccv_step_core u_core (
    .clk     (clk),
    .rst     (rst),
    .step_en (step_en),
    .item    (item),
    .cfg     (cfg),
    .result  (result)
  );

  // advance the held item whenever the result register is free or draining
  assign step_en  = item_valid && (!out_valid || out_ready);
  assign in_ready = !item_valid || step_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step_en) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_data <= result;
    end
  end

endmodule

`default_nettype wire

>>> sim/tb_top.sv
// Self-checking testbench for cccv_cycling_controller: handshake driver and monitor,
// step-level predictor of the CC-CV sequencer, and register loads between phases.
// Depends on cccv_pkg and the controller RTL.
`timescale 1ns / 1ps

module tb_top;
  import cccv_pkg::*;

  localparam int CLK_PERIOD = 8;
  localparam int ITEMS_PER_PHASE = 220;
  localparam int HOLD_CYCLES = 300;
  localparam int MAX_REPORTS = 10;
  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;
  localparam longint unsigned HC_MAX = (64'd1 << COUNT_WIDTH) - 1;
  localparam int CFG_TYPICAL = 0;
  localparam int CFG_HIGH = 1;
  localparam int CFG_LOW = 2;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  cccv_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  cccv_out_t out_data;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  cccv_cycling_controller DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // register copy and sequencer state of the predictor
  cccv_cfg_t cfg_shadow;
  logic chg_on;
  logic [31:0] hc_count;
  logic [1:0] chg_phase, dis_phase;
  logic [47:0] relax_end_chg, relax_end_dis;
  logic chg_pending;
  logic [31:0] last_step;

  cccv_in_t step_backlog[$];
  cccv_out_t predicted_status[$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int bad_results = 0;
  int hold_token = 0;
  int hold_seen;
  int hold_left;
  logic [31:0] step_ctr = '0;
  logic [47:0] time_ctr = '0;

  function automatic cccv_out_t advance_cycler(cccv_in_t it);
    cccv_out_t r;
    logic [1:0] cur;
    logic hit;
    logic [48:0] end_sum;
    logic [32:0] win_end;
    int sel;
    r = '0;
    if (hc_count == 0) begin
      if (cfg_shadow.cycle_mode[MODE_SKIP_INIT] || it.start_cycling) begin
        if (!cfg_shadow.cycle_mode[MODE_SKIP_INIT]) begin
          chg_pending = 1'b1;
          last_step = it.step_number;
          r.phase_advanced = 1'b1;
        end
        chg_on = cfg_shadow.cycle_mode[MODE_CHARGE_FIRST];
        hc_count = 32'd1;
        chg_phase = PH_CC;
        dis_phase = PH_CC;
      end
    end else begin
      cur = chg_on ? chg_phase : dis_phase;
      case (cur)
        PH_CC: begin
          hit = chg_on ? ($signed(it.cell_voltage) >= $signed(cfg_shadow.charge_cutoff_voltage))
                       : ($signed(it.cell_voltage) <= $signed(cfg_shadow.discharge_cutoff_voltage));
        end
        PH_CV: begin
          hit = chg_on ? ($signed(it.cell_crate) <= $signed(cfg_shadow.charge_cutoff_crate))
                       : ($signed(it.cell_crate) <= $signed(cfg_shadow.discharge_cutoff_crate));
        end
        default: begin
          hit = it.sim_time >= (chg_on ? relax_end_chg : relax_end_dis);
        end
      endcase
      if (hit) begin
        r.phase_advanced = 1'b1;
        chg_pending = 1'b1;
        last_step = it.step_number;
        if (cur == PH_CC) begin
          if (chg_on) chg_phase = PH_CV; else dis_phase = PH_CV;
        end else if (cur == PH_CV) begin
          // saturate the relaxation end at the top of the time range
          end_sum = {1'b0, it.sim_time} + {1'b0, chg_on ? cfg_shadow.charge_relax_time
                                                        : cfg_shadow.discharge_relax_time};
          if (end_sum[48]) end_sum[47:0] = '1;
          if (chg_on) begin
            relax_end_chg = end_sum[47:0];
            chg_phase = PH_RELAX;
          end else begin
            relax_end_dis = end_sum[47:0];
            dis_phase = PH_RELAX;
          end
        end else begin
          r.half_cycle_done = 1'b1;
          if (chg_on) dis_phase = PH_CC; else chg_phase = PH_CC;
          chg_on = !chg_on;
          if (64'(hc_count) < HC_MAX) hc_count = hc_count + 32'd1;
        end
      end
    end

    win_end = {1'b0, last_step} + {1'b0, cfg_shadow.adapt_window_steps};
    r.adapt_window_over = chg_pending && ({1'b0, it.step_number} >= win_end);
    if (r.adapt_window_over) chg_pending = 1'b0;

    if (hc_count == 0) begin
      r.phase = PH_INIT;
      r.adaptive_stepping = cfg_shadow.cycle_mode[MODE_ADAPT_INIT];
    end else begin
      r.phase = chg_on ? chg_phase : dis_phase;
      sel = (chg_on ? MODE_ADAPT_CHG : MODE_ADAPT_DIS) + int'(r.phase) - 1;
      r.adaptive_stepping = cfg_shadow.cycle_mode[sel];
    end
    r.charging = (hc_count != 0) && chg_on;
    r.half_cycle_number = hc_count[HCN_W-1:0];
    return r;
  endfunction

  // driver: hold the payload until transfer, then offer the next step or idle
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predicted_status.push_back(advance_cycler(in_data));
      if (!in_valid || in_ready) begin
        if (step_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= step_backlog.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, started whenever hold_token changes
  always @(posedge clk) begin
    if (rst) begin
      hold_seen <= 0;
      hold_left <= 0;
    end else if (hold_token != hold_seen) begin
      hold_seen <= hold_token;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor: compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    cccv_out_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (predicted_status.size() == 0) begin
          if (bad_results < MAX_REPORTS) $display("result with no step pending: %h", out_data);
          bad_results++;
        end else begin
          want = predicted_status.pop_front();
          if (out_data.phase !== want.phase || out_data.charging !== want.charging ||
              out_data.half_cycle_number !== want.half_cycle_number ||
              out_data.phase_advanced !== want.phase_advanced ||
              out_data.half_cycle_done !== want.half_cycle_done ||
              out_data.adapt_window_over !== want.adapt_window_over ||
              out_data.adaptive_stepping !== want.adaptive_stepping) begin
            if (bad_results < MAX_REPORTS) begin
              $display("mismatch: expected ph=%0d chg=%0b hc=%0d adv=%0b done=%0b over=%0b ad=%0b",
                       want.phase, want.charging, want.half_cycle_number, want.phase_advanced,
                       want.half_cycle_done, want.adapt_window_over, want.adaptive_stepping);
              $display("          actual   ph=%0d chg=%0b hc=%0d adv=%0b done=%0b over=%0b ad=%0b",
                       out_data.phase, out_data.charging, out_data.half_cycle_number,
                       out_data.phase_advanced, out_data.half_cycle_done,
                       out_data.adapt_window_over, out_data.adaptive_stepping);
            end
            bad_results++;
          end
        end
      end
      out_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  function automatic logic signed [31:0] pick_level(logic signed [31:0] cut_a,
                                                    logic signed [31:0] cut_b);
    int unsigned roll;
    longint v;
    roll = $urandom_range(0, 99);
    if (roll >= 90) return ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
    if (roll >= 80) return $urandom();
    // land on or next to a cut-off so that phases actually end
    v = longint'(roll < 40 ? cut_a : cut_b) + longint'(int'($urandom_range(0, 6)) - 3);
    if (v > S32_MAX) v = S32_MAX;
    else if (v < S32_MIN) v = S32_MIN;
    return v[31:0];
  endfunction

  function automatic cccv_cfg_t make_config(int kind);
    cccv_cfg_t c;
    case (kind)
      CFG_HIGH: begin
        c.cycle_mode = '1;
        c.charge_cutoff_voltage = 32'h7FFF_FFFF;
        c.discharge_cutoff_voltage = 32'h7FFF_FFFF;
        c.charge_cutoff_crate = 32'h7FFF_FFFF;
        c.discharge_cutoff_crate = 32'h7FFF_FFFF;
        c.charge_relax_time = '1;
        c.discharge_relax_time = '1;
        c.adapt_window_steps = '1;
      end
      CFG_LOW: begin
        c.cycle_mode = '0;
        c.charge_cutoff_voltage = 32'h8000_0000;
        c.discharge_cutoff_voltage = 32'h8000_0000;
        c.charge_cutoff_crate = 32'h8000_0000;
        c.discharge_cutoff_crate = 32'h8000_0000;
        c.charge_relax_time = '0;
        c.discharge_relax_time = '0;
        c.adapt_window_steps = '0;
      end
      default: begin
        c.cycle_mode = MODE_W'($urandom_range(0, 511));
        c.charge_cutoff_voltage = $urandom();
        c.discharge_cutoff_voltage = $urandom();
        c.charge_cutoff_crate = $urandom();
        c.discharge_cutoff_crate = $urandom();
        c.charge_relax_time = 48'($urandom_range(0, 40));
        c.discharge_relax_time = 48'($urandom_range(0, 40));
        c.adapt_window_steps = $urandom_range(0, 6);
      end
    endcase
    return c;
  endfunction

  task automatic load_config(cccv_cfg_t c);
    logic [CFG_DATA_W-1:0] vals [8];
    vals[REG_CYCLE_MODE] = {39'h0, c.cycle_mode};
    vals[REG_CHG_CUT_V] = {16'h0000, c.charge_cutoff_voltage};
    vals[REG_DIS_CUT_V] = {16'h0000, c.discharge_cutoff_voltage};
    vals[REG_CHG_CUT_C] = {16'h0000, c.charge_cutoff_crate};
    vals[REG_DIS_CUT_C] = {16'h0000, c.discharge_cutoff_crate};
    vals[REG_CHG_RELAX_T] = c.charge_relax_time;
    vals[REG_DIS_RELAX_T] = c.discharge_relax_time;
    vals[REG_ADAPT_WIN] = {16'h0000, c.adapt_window_steps};
    for (int i = 0; i < 8; i++) begin
      @(posedge clk);
      cfg_write <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data <= vals[i];
    end
    @(posedge clk);
    cfg_write <= 1'b0;
    cfg_shadow = c;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (step_backlog.size() != 0 || in_valid || predicted_status.size() != 0);
    // then idle before touching the registers
    repeat (4) @(negedge clk);
  endtask

  task automatic queue_step(logic start, logic [31:0] step, logic [47:0] t,
                            logic signed [31:0] volt, logic signed [31:0] crate);
    cccv_in_t it;
    it.start_cycling = start;
    it.step_number = step;
    it.sim_time = t;
    it.cell_voltage = volt;
    it.cell_crate = crate;
    step_backlog.push_back(it);
  endtask

  task automatic queue_random_steps(int count);
    cccv_in_t it;
    int unsigned roll;
    repeat (count) begin
      roll = $urandom_range(0, 99);
      if (roll < 85) step_ctr = step_ctr + 1;
      else if (roll < 95) step_ctr = step_ctr + $urandom_range(0, 10);
      else step_ctr = $urandom();
      roll = $urandom_range(0, 99);
      if (roll < 90) begin
        time_ctr = time_ctr + 48'($urandom_range(0, 12));
        it.sim_time = time_ctr;
      end else if (roll < 95) begin
        it.sim_time = 48'({$urandom(), $urandom()});
      end else begin
        it.sim_time = '1;
      end
      it.start_cycling = 1'($urandom_range(0, 1));
      it.step_number = step_ctr;
      it.cell_voltage = pick_level(cfg_shadow.charge_cutoff_voltage,
                                   cfg_shadow.discharge_cutoff_voltage);
      it.cell_crate = pick_level(cfg_shadow.charge_cutoff_crate, cfg_shadow.discharge_cutoff_crate);
      step_backlog.push_back(it);
    end
  endtask

  initial begin
    #(2_000_000);
    $display("simulation failed");
    $finish;
  end

  initial begin
    cccv_cfg_t c;
    logic d, skip_init, charge_first;
    logic signed [31:0] cc_miss;

    cfg_shadow = '0;
    cfg_shadow.cycle_mode = MODE_W'(1);
    chg_on = 1'b0;
    hc_count = '0;
    chg_phase = PH_CC;
    dis_phase = PH_CC;
    relax_end_chg = '0;
    relax_end_dis = '0;
    chg_pending = 1'b0;
    last_step = '0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // the initial relaxation happens once per run; the seed picks skip or start
    skip_init = 1'($urandom_range(0, 1));
    charge_first = 1'($urandom_range(0, 1));
    c.cycle_mode = {6'($urandom_range(0, 63)), 1'b1, skip_init, charge_first};
    c.charge_cutoff_voltage = 32'sd4200000;
    c.discharge_cutoff_voltage = 32'sd2800000;
    c.charge_cutoff_crate = 32'sd3277;
    c.discharge_cutoff_crate = 32'sd6554;
    c.charge_relax_time = 48'd10;
    c.discharge_relax_time = 48'd10;
    c.adapt_window_steps = 32'd2;
    load_config(c);
    @(negedge clk);

    d = charge_first;
    queue_step(1'b0, 32'd0, 48'd0, 32'h7FFF_FFFF, 32'h8000_0000);
    queue_step(1'b0, 32'd1, 48'd1, 32'h8000_0000, 32'h7FFF_FFFF);
    queue_step(1'b1, 32'd2, 48'd2, 32'sd0, 32'sd0);
    // constant current just short of and then exactly on the cut-off
    queue_step(1'b0, 32'd3, 48'd3, d ? 32'sd4199999 : 32'sd2800001, 32'sd0);
    queue_step(1'b0, 32'd4, 48'd4, d ? 32'sd4200000 : 32'sd2800000, 32'sd0);
    queue_step(1'b0, 32'd5, 48'd5, 32'sd0, d ? 32'sd3278 : 32'sd6555);
    queue_step(1'b0, 32'd6, 48'd6, 32'sd0, d ? 32'sd3277 : 32'sd6554);
    queue_step(1'b0, 32'd7, 48'd15, 32'sd0, 32'sd0);
    queue_step(1'b0, 32'd8, 48'd16, 32'sd0, 32'sd0);
    d = !d;
    // start request after cycling began is ignored
    queue_step(1'b1, 32'd9, 48'd17, d ? 32'h7FFF_FFFF : 32'h8000_0000, 32'sd0);
    queue_step(1'b0, 32'd10, 48'd18, 32'sd0, 32'h8000_0000);
    queue_step(1'b0, 32'd11, 48'hFFFF_FFFF_FFFF, 32'sd0, 32'sd0);
    d = !d;
    cc_miss = d ? 32'h8000_0000 : 32'h7FFF_FFFF;
    queue_step(1'b0, 32'd12, 48'd0, cc_miss, 32'sd0);
    queue_step(1'b0, 32'd13, 48'd1, cc_miss, 32'sd0);
    // change recorded at the last step number; the window sum must not wrap
    queue_step(1'b0, 32'hFFFF_FFFF, 48'd2, d ? 32'h7FFF_FFFF : 32'h8000_0000, 32'sd0);
    queue_step(1'b0, 32'd0, 48'd3, 32'sd0, 32'h7FFF_FFFF);
    queue_step(1'b0, 32'd1, 48'd4, 32'sd0, 32'h7FFF_FFFF);
    step_ctr = 32'd1;
    time_ctr = 48'd100;

    for (int ph = 0; ph < 5; ph++) begin
      wait_drained();
      case (ph)
        0: begin
          c = make_config(CFG_TYPICAL);
          send_idle_pct = 66;
          recv_stall_pct = 0;
        end
        1: begin
          c = make_config(CFG_HIGH);
          send_idle_pct = 0;
          recv_stall_pct = 66;
          time_ctr = 48'hFFFF_FFFF_FF00;
        end
        2: begin
          c = make_config(CFG_TYPICAL);
          send_idle_pct = 15;
          recv_stall_pct = 15;
        end
        3: begin
          c = make_config(CFG_LOW);
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        default: begin
          c = make_config(CFG_TYPICAL);
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
      endcase
      load_config(c);
      @(negedge clk);
      queue_random_steps(ITEMS_PER_PHASE);
      // back-pressure: keep the sender busy while the receiver holds off
      if (ph == 4) hold_token++;
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (bad_results == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
